@@ hdl/fq2d_pkg.sv @@
`default_nettype none
package fq2d_pkg;

    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_POINT = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_INT,
        ST_POINT,
        ST_FRAC
    } fq2d_state_t;

    typedef struct packed {
        logic load;
        logic shift_digit;
    } fq2d_bcd_ctrl_t;

    typedef struct packed {
        logic       busy;
        logic [3:0] top_digit;
    } fq2d_bcd_status_t;

    typedef struct packed {
        logic load;
        logic step;
    } fq2d_frac_ctrl_t;

    typedef struct packed {
        logic [3:0] digit;
        logic       next_zero;
        logic       is_zero;
    } fq2d_frac_status_t;

endpackage
`default_nettype wire

@@ hdl/fq2d_if.sv @@
`default_nettype none
interface fq2d_in_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] raw_value;

    modport source (output valid, output raw_value, input ready);
    modport sink (input valid, input raw_value, output ready);
endinterface

interface fq2d_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       last_char;

    modport source (output valid, output text_char, output last_char, input ready);
    modport sink (input valid, input text_char, input last_char, output ready);
endinterface
`default_nettype wire

@@ hdl/fq2d_bcd_conv.sv @@
`default_nettype none
module fq2d_bcd_conv #(
    parameter int INT_BITS   = 32,
    parameter int NUM_DIGITS = 10
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire fq2d_pkg::fq2d_bcd_ctrl_t  ctrl,
    input  wire logic [INT_BITS-1:0]       load_value,
    output      fq2d_pkg::fq2d_bcd_status_t status
);
    import fq2d_pkg::*;

    localparam int CW = $clog2(INT_BITS + 1);
    localparam int BW = 4 * NUM_DIGITS;

    logic [INT_BITS-1:0] bin_reg;
    logic [BW-1:0]       bcd_reg;
    logic [CW-1:0]       cnt_reg;
    logic [BW-1:0]       adj;

    // add 3 to every digit of five or more before the shift
    always_comb
    begin
        logic [3:0] d;
        adj = '0;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            d = bcd_reg[4*i +: 4];
            adj[4*i +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (ctrl.load)
        begin
            cnt_reg <= CW'(INT_BITS);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            bin_reg <= load_value;
            bcd_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            bcd_reg <= {adj[BW-2:0], bin_reg[INT_BITS-1]};
            bin_reg <= {bin_reg[INT_BITS-2:0], 1'b0};
        end
        else if (ctrl.shift_digit)
        begin
            bcd_reg <= {bcd_reg[BW-5:0], 4'd0};
        end
    end

    assign status.busy      = (cnt_reg != '0);
    assign status.top_digit = bcd_reg[BW-1 -: 4];

endmodule
`default_nettype wire

@@ hdl/fq2d_frac_unit.sv @@
`default_nettype none
module fq2d_frac_unit #(
    parameter int FRAC_BITS = 32
) (
    input  wire logic                        clk,
    input  wire fq2d_pkg::fq2d_frac_ctrl_t   ctrl,
    input  wire logic [FRAC_BITS-1:0]        load_value,
    output      fq2d_pkg::fq2d_frac_status_t status
);
    import fq2d_pkg::*;

    localparam int PW = FRAC_BITS + 4;

    logic [FRAC_BITS-1:0] frac_reg;
    logic [PW-1:0]        prod;

    // times ten as (x << 3) + (x << 1)
    assign prod = ({4'd0, frac_reg} << 3) + ({4'd0, frac_reg} << 1);

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            frac_reg <= load_value;
        end
        else if (ctrl.step)
        begin
            frac_reg <= prod[FRAC_BITS-1:0];
        end
    end

    assign status.digit     = prod[PW-1:FRAC_BITS];
    assign status.next_zero = (prod[FRAC_BITS-1:0] == '0);
    assign status.is_zero   = (frac_reg == '0);

endmodule
`default_nettype wire

@@ hdl/fixed_q32_32_to_decimal_text.sv @@
`default_nettype none
// Converts one signed 64-bit fixed-point value with FRAC_BITS fraction bits
// into its exact decimal text, one ASCII character per output transfer, with
// last_char marking the final character: an optional '-', the integer digits
// without leading zeros, and, for a nonzero fraction, '.' and the fraction
// digits without trailing zeros. Per value: the input is taken, the integer
// part runs through binary-to-BCD shift-and-add-3, the conversion state is
// left, then each character is loaded for output or each leading zero
// skipped in turn, characters waiting while the output stalls. Characters
// and skipped zeros together never exceed 1 + NUM_DIGITS + 1 + FRAC_BITS
// (44 at the default: sign, ten digit positions, point, 32 fraction
// digits). The input is not ready until the previous value's last
// character has been loaded for output.
module fixed_q32_32_to_decimal_text #(
    parameter int FRAC_BITS = 32
) (
    input wire logic   clk,
    input wire logic   rst_n,
    fq2d_in_if.sink    in_ch,
    fq2d_out_if.source out_ch
);
    import fq2d_pkg::*;

    localparam int INT_BITS   = 64 - FRAC_BITS;
    localparam int NUM_DIGITS = (INT_BITS * 1233) / 4096 + 1;
    localparam int DCW        = $clog2(NUM_DIGITS);

    fq2d_state_t       state_reg, state_next;
    logic              neg_reg;
    logic              started_reg, started_next;
    logic [DCW-1:0]    dcnt_reg, dcnt_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        char_reg, char_next;
    logic              last_reg, last_next;

    logic              accept;
    logic              can_load;
    logic [63:0]       mag;
    fq2d_bcd_ctrl_t    bcd_ctrl;
    fq2d_bcd_status_t  bcd_status;
    fq2d_frac_ctrl_t   frac_ctrl;
    fq2d_frac_status_t frac_status;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;
    assign can_load    = !out_valid_reg || out_ch.ready;
    assign mag         = in_ch.raw_value[63] ? (64'd0 - 64'(in_ch.raw_value))
                                             : 64'(in_ch.raw_value);

    fq2d_bcd_conv #(
        .INT_BITS   (INT_BITS),
        .NUM_DIGITS (NUM_DIGITS)
    ) u_bcd (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (bcd_ctrl),
        .load_value (mag[63:FRAC_BITS]),
        .status     (bcd_status)
    );

    fq2d_frac_unit #(
        .FRAC_BITS (FRAC_BITS)
    ) u_frac (
        .clk        (clk),
        .ctrl       (frac_ctrl),
        .load_value (mag[FRAC_BITS-1:0]),
        .status     (frac_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            started_reg   <= 1'b0;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            started_reg   <= started_next;
            dcnt_reg      <= dcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            neg_reg <= in_ch.raw_value[63];
        end
        char_reg <= char_next;
        last_reg <= last_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        started_next   = started_reg;
        dcnt_next      = dcnt_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        char_next      = char_reg;
        last_next      = last_reg;
        bcd_ctrl       = '0;
        frac_ctrl      = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    bcd_ctrl.load  = 1'b1;
                    frac_ctrl.load = 1'b1;
                    started_next   = 1'b0;
                    dcnt_next      = DCW'(NUM_DIGITS - 1);
                    state_next     = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (!bcd_status.busy)
                begin
                    state_next = neg_reg ? ST_SIGN : ST_INT;
                end
            end
            ST_SIGN:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    char_next      = CHAR_MINUS;
                    last_next      = 1'b0;
                    state_next     = ST_INT;
                end
            end
            ST_INT:
            begin
                if (bcd_status.top_digit == 4'd0 && !started_reg && dcnt_reg != '0)
                begin
                    // drop a leading zero
                    bcd_ctrl.shift_digit = 1'b1;
                    dcnt_next            = dcnt_reg - 1'b1;
                end
                else if (can_load)
                begin
                    out_valid_next       = 1'b1;
                    char_next            = CHAR_ZERO + {4'd0, bcd_status.top_digit};
                    last_next            = (dcnt_reg == '0) && frac_status.is_zero;
                    started_next         = 1'b1;
                    bcd_ctrl.shift_digit = 1'b1;
                    if (dcnt_reg == '0)
                    begin
                        state_next = frac_status.is_zero ? ST_IDLE : ST_POINT;
                    end
                    else
                    begin
                        dcnt_next = dcnt_reg - 1'b1;
                    end
                end
            end
            ST_POINT:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    char_next      = CHAR_POINT;
                    last_next      = 1'b0;
                    state_next     = ST_FRAC;
                end
            end
            ST_FRAC:
            begin
                if (can_load)
                begin
                    // a zero remainder means only zero digits would follow
                    out_valid_next = 1'b1;
                    char_next      = CHAR_ZERO + {4'd0, frac_status.digit};
                    last_next      = frac_status.next_zero;
                    frac_ctrl.step = 1'b1;
                    if (frac_status.next_zero)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.text_char = char_reg;
    assign out_ch.last_char = last_reg;

    a_accept_starts_conv: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_CONV)
        else $error("accepted value did not start conversion");

    a_bcd_busy_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
        bcd_status.busy |-> state_reg == ST_CONV)
        else $error("BCD unit busy outside conversion");

    a_frac_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FRAC |-> !frac_status.is_zero)
        else $error("fraction digits emitted from a zero remainder");

    a_point_needs_frac: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_POINT |-> !frac_status.is_zero)
        else $error("point pending with a zero fraction");

endmodule
`default_nettype wire

@@ tb/sv/fixed_q32_32_to_decimal_text_tb.sv @@
`timescale 1ns / 1ps

module fixed_q32_32_to_decimal_text_tb;
    import fq2d_pkg::*;

    localparam int IDLE_LIMIT   = 3000;
    localparam int TAIL_CYCLES  = 120;
    localparam int HOLD_CYCLES  = 500;
    localparam int HOLD_AFTER   = 300;
    localparam int RANDOM_ITEMS = 150;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } text_char_t;

    typedef struct {
        logic [63:0] value;
        bit          drain_first;
    } pending_value_t;

    logic clk;
    logic rst_n;

    fq2d_in_if  in_ch ();
    fq2d_out_if out_ch ();

    fixed_q32_32_to_decimal_text dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    pending_value_t values_to_send[$];
    text_char_t     due_chars[$];
    int             errors;
    int             chars_seen;
    int             idle_cycles;

    // sender state
    int burst_left;
    int gap_left;

    // receiver state
    int  ready_mode;
    int  mode_left;
    int  hold_left;
    bit  hold_done;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report(input string what);
        begin
            errors++;
            $display("[%0t] mismatch: %s", $realtime, what);
        end
    endtask

    // Build the exact decimal text of one fixed-point value and queue it.
    function automatic void spell_value(input logic [63:0] raw);
        logic [63:0] mag;
        logic [31:0] whole;
        logic [63:0] frac;
        logic [3:0]  int_digits [10];
        logic [3:0]  frac_digits [32];
        logic [7:0]  text [44];
        text_char_t  entry;
        int          n_int;
        int          n;
        int          last_nz;
        int          i;
        begin
            n = 0;
            n_int = 0;
            last_nz = 0;
            mag = raw[63] ? (64'd0 - raw) : raw;
            whole = mag[63:32];
            frac = {32'd0, mag[31:0]};
            if (raw[63])
            begin
                text[n] = CHAR_MINUS;
                n++;
            end
            do
            begin
                int_digits[n_int] = 4'(whole % 32'd10);
                whole = whole / 32'd10;
                n_int++;
            end while (whole != 32'd0);
            for (i = n_int - 1; i >= 0; i--)
            begin
                text[n] = CHAR_ZERO + 8'(int_digits[i]);
                n++;
            end
            if (frac != 64'd0)
            begin
                text[n] = CHAR_POINT;
                n++;
                for (i = 0; i < 32; i++)
                begin
                    frac = frac * 64'd10;
                    frac_digits[i] = frac[35:32];
                    frac[63:32] = 32'd0;
                    if (frac_digits[i] != 4'd0)
                        last_nz = i;
                end
                for (i = 0; i <= last_nz; i++)
                begin
                    text[n] = CHAR_ZERO + 8'(frac_digits[i]);
                    n++;
                end
            end
            for (i = 0; i < n; i++)
            begin
                entry.ch = text[i];
                entry.last = (i == n - 1);
                due_chars = {due_chars, entry};
            end
        end
    endfunction

    function automatic logic [63:0] pick_value();
        logic [63:0] v;
        int          kind;
        begin
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2: v = {$urandom, $urandom};
                3: v = {$urandom, 32'd0};
                4: v = {32'($urandom_range(0, 999)), 4'($urandom_range(0, 15)), 28'd0};
                5: v = {32'd0, 32'($urandom_range(1, 255))};
                6: v = ($urandom_range(0, 1) != 0)
                       ? 64'h8000_0000_0000_0000 + 64'($urandom_range(0, 3))
                       : 64'h7FFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3));
                default: v = {16'd0, 16'($urandom), $urandom};
            endcase
            if (kind >= 3 && kind != 6 && $urandom_range(0, 1) != 0)
                v = 64'd0 - v;
            return v;
        end
    endfunction

    task automatic queue_value(input logic [63:0] v, input bit drain_first);
        pending_value_t p;
        begin
            p.value = v;
            p.drain_first = drain_first;
            values_to_send = {values_to_send, p};
        end
    endtask

    // stimulus and end of run
    initial
    begin
        int i;
        errors = 0;
        chars_seen = 0;
        idle_cycles = 0;
        burst_left = 0;
        gap_left = 0;
        ready_mode = 0;
        mode_left = 0;
        hold_left = 0;
        hold_done = 0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.raw_value = 64'd0;
        out_ch.ready = 1'b0;

        queue_value(64'h0000_0000_0000_0000, 1'b0);  // zero
        queue_value(64'h0000_0000_0000_0001, 1'b0);  // smallest fraction, all digits
        queue_value(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        queue_value(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);  // largest value
        queue_value(64'h8000_0000_0000_0000, 1'b0);  // most negative
        queue_value(64'h8000_0000_0000_0001, 1'b0);  // longest text
        queue_value(64'h0000_0001_0000_0000, 1'b0);
        queue_value(64'hFFFF_FFFF_0000_0000, 1'b0);
        queue_value(64'h7FFF_FFFF_0000_0000, 1'b0);
        queue_value(64'h0000_0000_8000_0000, 1'b0);
        queue_value(64'hFFFF_FFFF_8000_0000, 1'b0);
        queue_value(64'h0000_0000_FFFF_FFFF, 1'b0);
        queue_value(64'h0000_000A_4000_0000, 1'b0);
        queue_value(64'h3B9A_CA00_0000_0000, 1'b0);
        queue_value(64'hC465_3600_1999_999A, 1'b0);
        queue_value(64'h5555_5555_AAAA_AAAA, 1'b0);
        queue_value(64'hAAAA_AAAA_5555_5555, 1'b0);
        queue_value(64'h0000_0009_0000_0000, 1'b0);
        for (i = 0; i < RANDOM_ITEMS; i++)
            queue_value(pick_value(), (i == 60) || (i == 110));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // sample between edges so the sender and monitor have settled
        @(negedge clk);
        while (values_to_send.size() != 0 || in_ch.valid || due_chars.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("fixed_q32_32_to_decimal_text_tb: done, clean");
        else
            $display("fixed_q32_32_to_decimal_text_tb: done, errors");
        $finish;
    end

    // sender: bursts with random gaps, two pauses until all text has drained
    always @(posedge clk)
    begin
        bit accepted;
        bit next_valid;
        accepted = in_ch.valid && in_ch.ready;
        next_valid = in_ch.valid;
        if (rst_n && !(in_ch.valid && !accepted))
        begin
            if (accepted)
            begin
                spell_value(in_ch.raw_value);
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
            next_valid = 1'b0;
            if (gap_left > 0)
                gap_left--;
            else if (values_to_send.size() != 0)
            begin
                if (!values_to_send[0].drain_first || due_chars.size() == 0)
                begin
                    next_valid = 1'b1;
                    in_ch.raw_value <= values_to_send[0].value;
                    void'(values_to_send.pop_front());
                    if (burst_left == 0)
                        burst_left = $urandom_range(1, 10);
                end
            end
            in_ch.valid <= next_valid;
        end
    end

    // receiver: stall pattern in changing modes, one long hold-off
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (!hold_done && chars_seen >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    ready_mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(20, 200);
                end
                else
                    mode_left--;
                case (ready_mode)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= ($urandom_range(0, 1) != 0);
                    default: out_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        text_char_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            chars_seen++;
            if (due_chars.size() == 0)
                report($sformatf("char 0x%02h with nothing outstanding", out_ch.text_char));
            else
            begin
                want = due_chars.pop_front();
                if (out_ch.text_char !== want.ch)
                    report($sformatf("text_char 0x%02h, want 0x%02h",
                                     out_ch.text_char, want.ch));
                if (out_ch.last_char !== want.last)
                    report($sformatf("last_char %b, want %b on char 0x%02h",
                                     out_ch.last_char, want.last, want.ch));
            end
        end
    end

    // watchdog: no transfer on either side for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("fixed_q32_32_to_decimal_text_tb: done, errors");
                $finish;
            end
        end
    end

endmodule
